// ----- hw/rtl/ledseq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the LED animation sequencer.
// No dependencies; imported by led_animation_sequencer_unit.
package ledseq_pkg;

  localparam int OPCODE_W     = 3;
  localparam int ANIM_ID_W    = 8;
  localparam int LED_INDEX_W  = 8;
  localparam int RAND_W       = 32;
  localparam int LEVELS_W     = 6;
  localparam int ANIM_W       = 3;
  localparam int STEP_TICKS_W = 16;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [STEP_TICKS_W-1:0] CHASE_TICKS_RST   = 16'd150;
  localparam logic [STEP_TICKS_W-1:0] TWINKLE_TICKS_RST = 16'd80;
  localparam logic [STEP_TICKS_W-1:0] WAVE_TICKS_RST    = 16'd300;
  localparam logic [STEP_TICKS_W-1:0] BLINK_TICKS_RST   = 16'd150;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_SET_ONE = 3'd3,
    OP_SET_ALL = 3'd4
  } opcode_t;

  typedef enum logic [ANIM_W-1:0] {
    ANIM_NONE    = 3'd0,
    ANIM_CHASE   = 3'd1,
    ANIM_TWINKLE = 3'd2,
    ANIM_WAVE    = 3'd3,
    ANIM_BLINK   = 3'd4
  } anim_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHASE_TICKS   = 2'd0,
    CFG_TWINKLE_TICKS = 2'd1,
    CFG_WAVE_TICKS    = 2'd2,
    CFG_BLINK_TICKS   = 2'd3
  } cfg_reg_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_ARG = 1'b1;

endpackage

// ----- hw/rtl/led_animation_sequencer_unit.sv -----
`timescale 1ns / 1ps
// LED animation sequencer: usage
//   Input channel (in_valid / in_stall) carries one request per tick or command:
//   opcode, anim_id, led_index, on_level, rand_value, rand_bit. A request is taken
//   on a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns exactly one result per request:
//   led_levels (low six LEDs), status, animation, running.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the four
//   step-length registers; cfg_ready is always high. Write only while idle.
//   A request passes through the input register and then the result register.
//   Throughput: one request per cycle while out_stall is low; the state update is
//   a single pass of logic between the input register and the result register.
//   The twinkle LED is rand_value modulo LED_COUNT, folded in nibbles before the
//   input register and finished through a 256-entry lookup after it.
//   Reset (rst, synchronous): all LEDs off, no animation, counters cleared,
//   step registers back to 150/80/300/150, both pipeline stages empty.
//   When the receiver stalls, the result holds; the input register keeps taking
//   requests until it is also full, then in_stall rises.
module led_animation_sequencer_unit #(
  parameter int LED_COUNT = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ledseq_pkg::OPCODE_W-1:0]      opcode,
  input  logic [ledseq_pkg::ANIM_ID_W-1:0]     anim_id,
  input  logic [ledseq_pkg::LED_INDEX_W-1:0]   led_index,
  input  logic                                 on_level,
  input  logic [ledseq_pkg::RAND_W-1:0]        rand_value,
  input  logic                                 rand_bit,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ledseq_pkg::LEVELS_W-1:0]      led_levels,
  output logic                                 status,
  output logic [ledseq_pkg::ANIM_W-1:0]        animation,
  output logic                                 running,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ledseq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ledseq_pkg::STEP_TICKS_W-1:0]  cfg_data
);
  import ledseq_pkg::*;

  localparam int IDX_W   = (LED_COUNT > 2) ? $clog2(LED_COUNT) : 1;
  localparam int STEPS   = 2 * LED_COUNT - 1;
  localparam int POS_W   = $clog2(STEPS);
  localparam int WIDE_W  = (LED_COUNT > LEVELS_W) ? LED_COUNT : LEVELS_W;
  localparam int FOLD_W  = 11;
  localparam int NIBBLES = RAND_W / 4;
  localparam int R16     = 16 % LED_COUNT;
  localparam int R256    = 256 % LED_COUNT;

  function automatic logic [LED_COUNT-1:0] even_fill();
    logic [LED_COUNT-1:0] m;
    m = '0;
    for (int i = 0; i < LED_COUNT; i += 2) begin
      m[i] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [LED_COUNT-1:0] EVEN_MASK = even_fill();
  localparam logic [LED_COUNT-1:0] ONE_HOT0  = {{(LED_COUNT-1){1'b0}}, 1'b1};

  // configuration registers
  logic [STEP_TICKS_W-1:0] chase_ticks, twinkle_ticks, wave_ticks, blink_ticks;

  // sequencer state
  logic [LED_COUNT-1:0]    led_bank, led_bank_next;
  anim_t                   mode, mode_next;
  logic [POS_W-1:0]        pos, pos_next;
  logic [STEP_TICKS_W-1:0] tick, tick_next;
  logic                    status_next;

  // input register
  logic                    s1_valid;
  logic [OPCODE_W-1:0]     s1_opcode;
  logic [ANIM_ID_W-1:0]    s1_id;
  logic [LED_INDEX_W-1:0]  s1_index;
  logic                    s1_on;
  logic [FOLD_W-1:0]       s1_fold;
  logic                    s1_rb;

  logic in_accept, advance;

  // residue of rand_value: weighted nibble sum, then two narrow folds and a table
  logic [FOLD_W-1:0] fold_term [NIBBLES];
  logic [FOLD_W-1:0] fold_sum;
  logic [8:0]        fold2;
  logic [7:0]        fold3;
  logic [IDX_W-1:0]  mod_lut [256];
  logic [IDX_W-1:0]  twinkle_led;

  genvar g;
  generate
    for (g = 0; g < NIBBLES; g++) begin : g_fold
      assign fold_term[g] = FOLD_W'(rand_value[4*g +: 4])
                            * FOLD_W'((1 << (4 * g)) % LED_COUNT);
    end
    for (g = 0; g < 256; g++) begin : g_lut
      assign mod_lut[g] = IDX_W'(g % LED_COUNT);
    end
  endgenerate

  always_comb begin
    fold_sum = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      fold_sum = fold_sum + fold_term[i];
    end
  end

  assign fold2 = 9'(s1_fold[3:0]) + 9'(s1_fold[7:4]) * 9'(R16)
               + 9'(s1_fold[10:8]) * 9'(R256);
  assign fold3 = 8'(fold2[3:0]) + 8'(fold2[7:4]) * 8'(R16)
               + 8'(fold2[8]) * 8'(R256);
  assign twinkle_led = mod_lut[fold3];

  // handshake
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  function automatic logic [LED_COUNT-1:0] apply_step(
    anim_t                m,
    logic [POS_W-1:0]     p,
    logic [LED_COUNT-1:0] b,
    logic [IDX_W-1:0]     tl,
    logic                 rb
  );
    logic [LED_COUNT-1:0] r;
    logic [POS_W-1:0]     led;
    r   = b;
    led = '0;
    case (m)
      ANIM_CHASE: begin
        led = (p < POS_W'(LED_COUNT)) ? p : POS_W'(2 * LED_COUNT - 2) - p;
        r   = ONE_HOT0 << led;
      end
      ANIM_TWINKLE: r[tl] = ~rb;
      ANIM_WAVE:    r = (p == '0) ? EVEN_MASK : ~EVEN_MASK;
      ANIM_BLINK:   r = (p == '0) ? '1 : '0;
      default:      r = b;
    endcase
    return r;
  endfunction

  logic [STEP_TICKS_W:0] tick_inc;
  logic [STEP_TICKS_W:0] step_len;
  logic [POS_W:0]        pos_inc;
  logic [POS_W:0]        step_cnt;
  logic [LED_COUNT-1:0]  base_bank;
  logic                  busy;

  always_comb begin
    busy     = (mode != ANIM_NONE);
    tick_inc = {1'b0, tick} + 1'b1;
    pos_inc  = {1'b0, pos} + 1'b1;
    case (mode)
      ANIM_CHASE:   step_len = {1'b0, chase_ticks};
      ANIM_TWINKLE: step_len = {1'b0, twinkle_ticks};
      ANIM_WAVE:    step_len = {1'b0, wave_ticks};
      default:      step_len = {1'b0, blink_ticks};
    endcase
    case (mode)
      ANIM_CHASE:   step_cnt = (POS_W+1)'(STEPS);
      ANIM_TWINKLE: step_cnt = (POS_W+1)'(1);
      default:      step_cnt = (POS_W+1)'(2);
    endcase
    base_bank = busy ? '0 : led_bank;

    led_bank_next = led_bank;
    mode_next     = mode;
    pos_next      = pos;
    tick_next     = tick;
    status_next   = STATUS_OK;

    case (s1_opcode)
      OP_TICK: begin
        if (busy) begin
          if (tick_inc >= step_len) begin
            tick_next     = '0;
            pos_next      = (pos_inc >= step_cnt) ? '0 : pos_inc[POS_W-1:0];
            led_bank_next = apply_step(mode, pos_next, led_bank, twinkle_led, s1_rb);
          end else begin
            tick_next = tick_inc[STEP_TICKS_W-1:0];
          end
        end
      end
      OP_START: begin
        if (s1_id > ANIM_ID_W'(ANIM_BLINK)) begin
          status_next = STATUS_BAD_ARG;
        end else begin
          // id zero acts as stop; a running animation halts before the new one
          mode_next     = anim_t'(s1_id[ANIM_W-1:0]);
          pos_next      = '0;
          tick_next     = '0;
          led_bank_next = (s1_id == '0) ? '0
                        : apply_step(anim_t'(s1_id[ANIM_W-1:0]), '0, base_bank,
                                     twinkle_led, s1_rb);
        end
      end
      OP_STOP: begin
        mode_next     = ANIM_NONE;
        pos_next      = '0;
        tick_next     = '0;
        led_bank_next = '0;
      end
      OP_SET_ONE: begin
        if (s1_index >= LED_INDEX_W'(LED_COUNT)) begin
          status_next = STATUS_BAD_ARG;
        end else begin
          mode_next     = ANIM_NONE;
          pos_next      = '0;
          tick_next     = '0;
          led_bank_next = base_bank;
          led_bank_next[s1_index[IDX_W-1:0]] = s1_on;
        end
      end
      OP_SET_ALL: begin
        mode_next     = ANIM_NONE;
        pos_next      = '0;
        tick_next     = '0;
        led_bank_next = s1_on ? '1 : '0;
      end
      default: status_next = STATUS_BAD_ARG;
    endcase
  end

  logic [WIDE_W-1:0] bank_wide;
  assign bank_wide = WIDE_W'(led_bank_next);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chase_ticks   <= CHASE_TICKS_RST;
      twinkle_ticks <= TWINKLE_TICKS_RST;
      wave_ticks    <= WAVE_TICKS_RST;
      blink_ticks   <= BLINK_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHASE_TICKS:   chase_ticks   <= cfg_data;
        CFG_TWINKLE_TICKS: twinkle_ticks <= cfg_data;
        CFG_WAVE_TICKS:    wave_ticks    <= cfg_data;
        CFG_BLINK_TICKS:   blink_ticks   <= cfg_data;
        default:           chase_ticks   <= chase_ticks;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode <= opcode;
      s1_id     <= anim_id;
      s1_index  <= led_index;
      s1_on     <= on_level;
      s1_fold   <= fold_sum;
      s1_rb     <= rand_bit;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      led_bank  <= '0;
      mode      <= ANIM_NONE;
      pos       <= '0;
      tick      <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        led_bank <= led_bank_next;
        mode     <= mode_next;
        pos      <= pos_next;
        tick     <= tick_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      led_levels <= bank_wide[LEVELS_W-1:0];
      status     <= status_next;
      animation  <= mode_next;
      running    <= (mode_next != ANIM_NONE);
    end
  end

`ifndef SYNTHESIS
  // an idle sequencer keeps its step counters cleared
  assert property (@(posedge clk) disable iff (rst)
    (mode == ANIM_NONE) |-> (pos == '0 && tick == '0))
    else $error("step counters not cleared while idle");

  assert property (@(posedge clk) disable iff (rst)
    (pos_inc <= (POS_W+1)'(STEPS)) && (tick != '1))
    else $error("step position or tick count out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (running == (animation != ANIM_NONE)))
    else $error("running flag disagrees with animation");

  // a result not taken must not be overwritten by a moving request
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && s1_valid) |=> (s1_valid && out_valid))
    else $error("request dropped under stall");
`endif

endmodule

// ----- test/tb_led_animation_sequencer_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for led_animation_sequencer_unit: directed requests, then
// random animation episodes under several step-length settings, with random stalls.
// Depends on ledseq_pkg and the unit under test; needs no files or arguments.
module tb_led_animation_sequencer_unit;
  import ledseq_pkg::*;

  localparam int LED_COUNT = 6;
  // Opcodes past set-all and animation ids past blink are rejected by the unit
  localparam logic [OPCODE_W-1:0] OP_BAD_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_BAD_LAST = 3'd7;
  localparam logic [ANIM_ID_W-1:0] ANIM_ID_FIRST_BAD = 8'd5;
  localparam logic [ANIM_ID_W-1:0] ANIM_ID_MAX = 8'hFF;
  localparam int HOLD_OFF_AT = 240;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int PHASE_REQUESTS = 145;

  typedef struct packed {
    logic [OPCODE_W-1:0]    opcode;
    logic [ANIM_ID_W-1:0]   anim_id;
    logic [LED_INDEX_W-1:0] led_index;
    logic                   on_level;
    logic [RAND_W-1:0]      rand_value;
    logic                   rand_bit;
  } request_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] levels;
    logic                status;
    anim_t               anim;
    logic                running;
  } led_state_t;

  typedef struct {
    request_t   req;
    bit         typed;
    led_state_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [OPCODE_W-1:0] opcode;
  logic [ANIM_ID_W-1:0] anim_id;
  logic [LED_INDEX_W-1:0] led_index;
  logic on_level;
  logic [RAND_W-1:0] rand_value;
  logic rand_bit;
  logic out_valid;
  logic out_stall;
  logic [LEVELS_W-1:0] led_levels;
  logic status;
  logic [ANIM_W-1:0] animation;
  logic running;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [STEP_TICKS_W-1:0] cfg_data;

  // Predicted sequencer state
  logic [LEVELS_W-1:0] led_bank_q = '0;
  anim_t anim_q = ANIM_NONE;
  int unsigned step_q = 0;
  int unsigned tick_q = 0;
  int unsigned chase_ticks = CHASE_TICKS_RST;
  int unsigned twinkle_ticks = TWINKLE_TICKS_RST;
  int unsigned wave_ticks = WAVE_TICKS_RST;
  int unsigned blink_ticks = BLINK_TICKS_RST;

  led_state_t expected_leds[$];
  script_row_t directed_script[$];
  int requests_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int steps_advanced = 0;
  int settings_used = 0;
  bit feed_calm = 1'b0;
  bit sink_calm = 1'b0;

  led_animation_sequencer_unit #(.LED_COUNT(LED_COUNT)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .anim_id(anim_id), .led_index(led_index), .on_level(on_level),
    .rand_value(rand_value), .rand_bit(rand_bit),
    .out_valid(out_valid), .out_stall(out_stall),
    .led_levels(led_levels), .status(status), .animation(animation), .running(running),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned ticks_per_step();
    case (anim_q)
      ANIM_CHASE: return chase_ticks;
      ANIM_TWINKLE: return twinkle_ticks;
      ANIM_WAVE: return wave_ticks;
      default: return blink_ticks;
    endcase
  endfunction

  function automatic int unsigned steps_per_cycle();
    case (anim_q)
      ANIM_CHASE: return 2 * LED_COUNT - 1;
      ANIM_TWINKLE: return 1;
      default: return 2;
    endcase
  endfunction

  task automatic halt_animation();
    anim_q = ANIM_NONE;
    step_q = 0;
    tick_q = 0;
    led_bank_q = '0;
  endtask

  // Apply the pattern of the current step
  task automatic show_step(input logic [RAND_W-1:0] rv, input logic rb);
    int unsigned pos;
    logic [LEVELS_W-1:0] even_leds;
    even_leds = '0;
    for (int i = 0; i < LED_COUNT; i += 2) even_leds[i] = 1'b1;
    case (anim_q)
      ANIM_CHASE: begin
        pos = (step_q < LED_COUNT) ? step_q : 2 * LED_COUNT - 2 - step_q;
        led_bank_q = '0;
        led_bank_q[pos % LED_COUNT] = 1'b1;
      end
      ANIM_TWINKLE: begin
        pos = rv % LED_COUNT;
        led_bank_q[pos] = ~rb;
      end
      ANIM_WAVE: led_bank_q = (step_q == 0) ? even_leds : ~even_leds;
      ANIM_BLINK: led_bank_q = (step_q == 0) ? '1 : '0;
      default: ;
    endcase
  endtask

  task automatic advance_sequencer(input request_t req, output led_state_t res);
    logic st;
    st = STATUS_OK;
    case (req.opcode)
      OP_TICK: begin
        if (anim_q != ANIM_NONE) begin
          tick_q++;
          if (tick_q >= ticks_per_step()) begin
            tick_q = 0;
            step_q++;
            if (step_q >= steps_per_cycle()) step_q = 0;
            show_step(req.rand_value, req.rand_bit);
            steps_advanced++;
          end
        end
      end
      OP_START: begin
        if (req.anim_id > ANIM_ID_W'(ANIM_BLINK)) begin
          st = STATUS_BAD_ARG;
        end else if (req.anim_id == ANIM_ID_W'(ANIM_NONE)) begin
          halt_animation();
        end else begin
          // idle start keeps the LEDs as they are
          if (anim_q != ANIM_NONE) halt_animation();
          anim_q = anim_t'(req.anim_id[ANIM_W-1:0]);
          step_q = 0;
          tick_q = 0;
          show_step(req.rand_value, req.rand_bit);
        end
      end
      OP_STOP: halt_animation();
      OP_SET_ONE: begin
        if (req.led_index >= LED_COUNT) begin
          st = STATUS_BAD_ARG;
        end else begin
          if (anim_q != ANIM_NONE) halt_animation();
          led_bank_q[req.led_index] = req.on_level;
        end
      end
      OP_SET_ALL: begin
        if (anim_q != ANIM_NONE) halt_animation();
        led_bank_q = req.on_level ? '1 : '0;
      end
      default: st = STATUS_BAD_ARG;
    endcase
    res.levels = led_bank_q;
    res.status = st;
    res.anim = anim_q;
    res.running = (anim_q != ANIM_NONE);
  endtask

  task automatic add_row(input logic [OPCODE_W-1:0] op, input logic [ANIM_ID_W-1:0] id,
                         input logic [LED_INDEX_W-1:0] idx, input logic on,
                         input logic [RAND_W-1:0] rv, input logic rb, input bit typed,
                         input logic [LEVELS_W-1:0] levels, input logic st, input anim_t anim);
    script_row_t row;
    row.req = '{op, id, idx, on, rv, rb};
    row.typed = typed;
    row.want = '{levels, st, anim, anim != ANIM_NONE};
    directed_script.push_back(row);
  endtask

  // Offer one request, wait for it to be taken, then record what it should produce
  task automatic send_request(input request_t req, input bit typed, input led_state_t want);
    int gap;
    led_state_t predicted;
    if (requests_sent % 64 == 0) feed_calm = ($urandom_range(0, 3) == 0);
    gap = feed_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= req.opcode;
    anim_id <= req.anim_id;
    led_index <= req.led_index;
    on_level <= req.on_level;
    rand_value <= req.rand_value;
    rand_bit <= req.rand_bit;
    do @(posedge clk); while (in_stall);
    advance_sequencer(req, predicted);
    expected_leds.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  function automatic request_t make_request(input logic [OPCODE_W-1:0] op);
    request_t req;
    int pick;
    req.opcode = op;
    req.anim_id = ANIM_ID_W'($urandom_range(0, 255));
    req.led_index = LED_INDEX_W'($urandom_range(0, 255));
    req.on_level = 1'($urandom_range(0, 1));
    req.rand_value = $urandom;
    req.rand_bit = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (op == OP_START) begin
      if (pick < 85)
        req.anim_id = ANIM_ID_W'($urandom_range(int'(ANIM_CHASE), int'(ANIM_BLINK)));
      else if (pick < 92)
        req.anim_id = ANIM_ID_W'(ANIM_NONE);
      else
        req.anim_id = ANIM_ID_W'($urandom_range(int'(ANIM_ID_FIRST_BAD), int'(ANIM_ID_MAX)));
    end else if (op == OP_SET_ONE && pick < 85) begin
      req.led_index = LED_INDEX_W'($urandom_range(0, LED_COUNT - 1));
    end
    return req;
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_command();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) return OP_START;
    if (pick < 10) return OP_STOP;
    if (pick < 14) return OP_SET_ONE;
    if (pick < 17) return OP_SET_ALL;
    return OPCODE_W'($urandom_range(int'(OP_BAD_FIRST), int'(OP_BAD_LAST)));
  endfunction

  task automatic write_step_ticks(input cfg_reg_t which, input logic [STEP_TICKS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (which)
      CFG_CHASE_TICKS: chase_ticks = val;
      CFG_TWINKLE_TICKS: twinkle_ticks = val;
      CFG_WAVE_TICKS: wave_ticks = val;
      default: blink_ticks = val;
    endcase
  endtask

  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Mostly: start an animation and feed it ticks, with a stray command now and then
  task automatic run_phase(input logic [STEP_TICKS_W-1:0] chase, twinkle, wave, blink);
    int stop_at;
    int run_len;
    write_step_ticks(CFG_CHASE_TICKS, chase);
    write_step_ticks(CFG_TWINKLE_TICKS, twinkle);
    write_step_ticks(CFG_WAVE_TICKS, wave);
    write_step_ticks(CFG_BLINK_TICKS, blink);
    cfg_valid <= 1'b0;
    settings_used++;
    stop_at = requests_sent + PHASE_REQUESTS;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 4) != 0) begin
        send_request(make_request(OP_START), 1'b0, '0);
        run_len = $urandom_range(1, 30);
        repeat (run_len) begin
          if ($urandom_range(0, 9) == 0)
            send_request(make_request(pick_command()), 1'b0, '0);
          else
            send_request(make_request(OP_TICK), 1'b0, '0);
        end
      end else begin
        send_request(make_request(pick_command()), 1'b0, '0);
      end
    end
    drain_results(4);
  endtask

  initial begin : request_feed
    rst <= 1'b1;
    in_valid <= 1'b0;
    opcode <= OP_TICK;
    anim_id <= '0;
    led_index <= '0;
    on_level <= 1'b0;
    rand_value <= '0;
    rand_bit <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CHASE_TICKS;
    cfg_data <= '0;

    add_row(OP_TICK, '0, '0, 1'b0, '0, 1'b0, 1, 6'b000000, STATUS_OK, ANIM_NONE);
    add_row(OP_STOP, '0, '0, 1'b0, '0, 1'b0, 1, 6'b000000, STATUS_OK, ANIM_NONE);
    add_row(OP_SET_ONE, '0, 8'd5, 1'b1, '0, 1'b0, 1, 6'b100000, STATUS_OK, ANIM_NONE);
    add_row(OP_SET_ONE, '0, 8'd6, 1'b1, '0, 1'b0, 1, 6'b100000, STATUS_BAD_ARG, ANIM_NONE);
    add_row(OP_SET_ONE, '0, 8'hFF, 1'b0, '0, 1'b0, 1, 6'b100000, STATUS_BAD_ARG, ANIM_NONE);
    add_row(OP_SET_ALL, '0, '0, 1'b1, '0, 1'b0, 1, 6'b111111, STATUS_OK, ANIM_NONE);
    add_row(OP_SET_ONE, '0, 8'd0, 1'b0, '0, 1'b0, 1, 6'b111110, STATUS_OK, ANIM_NONE);
    add_row(OP_START, ANIM_ID_W'(ANIM_TWINKLE), '0, 1'b0, '1, 1'b1, 0, '0, STATUS_OK, ANIM_NONE);
    add_row(OP_START, ANIM_ID_FIRST_BAD, '0, 1'b0, '0, 1'b0, 0, '0, STATUS_OK, ANIM_NONE);
    add_row(OP_START, ANIM_ID_MAX, '1, 1'b1, '1, 1'b1, 0, '0, STATUS_OK, ANIM_NONE);
    add_row(OP_BAD_FIRST, '0, '0, 1'b0, '0, 1'b0, 0, '0, STATUS_OK, ANIM_NONE);
    add_row(OP_BAD_LAST, '1, '1, 1'b1, '1, 1'b1, 0, '0, STATUS_OK, ANIM_NONE);
    add_row(OP_TICK, '1, '1, 1'b1, '1, 1'b1, 0, '0, STATUS_OK, ANIM_NONE);
    add_row(OP_START, ANIM_ID_W'(ANIM_CHASE), '0, 1'b0, '0, 1'b0, 1, 6'b000001, STATUS_OK,
            ANIM_CHASE);
    add_row(OP_SET_ONE, '0, 8'd2, 1'b1, '0, 1'b0, 1, 6'b000100, STATUS_OK, ANIM_NONE);
    add_row(OP_START, ANIM_ID_W'(ANIM_WAVE), '0, 1'b0, '0, 1'b0, 1, 6'b010101, STATUS_OK,
            ANIM_WAVE);
    add_row(OP_START, ANIM_ID_W'(ANIM_BLINK), '0, 1'b0, '0, 1'b0, 1, 6'b111111, STATUS_OK,
            ANIM_BLINK);
    add_row(OP_SET_ALL, '0, '0, 1'b0, '0, 1'b0, 1, 6'b000000, STATUS_OK, ANIM_NONE);
    add_row(OP_START, ANIM_ID_W'(ANIM_BLINK), '0, 1'b0, '0, 1'b0, 1, 6'b111111, STATUS_OK,
            ANIM_BLINK);
    add_row(OP_START, ANIM_ID_W'(ANIM_NONE), '0, 1'b0, '0, 1'b0, 1, 6'b000000, STATUS_OK,
            ANIM_NONE);
    add_row(OP_START, ANIM_ID_W'(ANIM_TWINKLE), '0, 1'b0, '0, 1'b0, 1, 6'b000001, STATUS_OK,
            ANIM_TWINKLE);
    add_row(OP_SET_ONE, '0, 8'd5, 1'b0, '0, 1'b0, 1, 6'b000000, STATUS_OK, ANIM_NONE);
    add_row(OP_START, ANIM_ID_W'(ANIM_CHASE), '0, 1'b1, '1, 1'b1, 0, '0, STATUS_OK, ANIM_NONE);
    add_row(OP_STOP, '1, '1, 1'b1, '1, 1'b1, 1, 6'b000000, STATUS_OK, ANIM_NONE);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_script[i])
      send_request(directed_script[i].req, directed_script[i].typed, directed_script[i].want);
    drain_results(4);

    run_phase(16'd1, 16'd1, 16'd1, 16'd1);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(16'd3, 16'd2, 16'd1, 16'd2);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(16'd2, 16'd5, 16'd4, 16'd3);
    run_phase(16'd1, 16'd3, 16'd2, 16'd1);
    repeat (4) @(posedge clk);

    $display("covered %0d requests (directed, then %0d step-length settings); %0d results checked",
             requests_sent, settings_used, results_checked);
    $display("animation steps advanced: %0d, mismatches: %0d", steps_advanced, mismatches);
    if (mismatches == 0)
      $display("tb_led_animation_sequencer_unit: PASS");
    else
      $display("tb_led_animation_sequencer_unit: FAIL");
    $finish;
  end

  initial begin : result_sink
    int gap;
    led_state_t want;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (results_checked % 50 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      // one long hold so the unit backs up and stalls its input
      if (results_checked == HOLD_OFF_AT)
        gap = HOLD_OFF_CYCLES;
      else
        gap = sink_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (expected_leds.size() == 0) begin
        $error("result with no request outstanding: led_levels %b", led_levels);
        mismatches++;
      end else begin
        want = expected_leds.pop_front();
        if (led_levels !== want.levels) begin
          $error("led_levels: expected %b, got %b", want.levels, led_levels);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (animation !== want.anim) begin
          $error("animation: expected %0d, got %0d", want.anim, animation);
          mismatches++;
        end
        if (running !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, running);
          mismatches++;
        end
      end
      results_checked++;
    end
  end

  initial begin : watchdog
    #(10_000_000);
    $display("tb_led_animation_sequencer_unit: FAIL");
    $finish;
  end

endmodule
